FILE: sv/mandel_pkg.sv
// Shared types, constants and state encoding for the Mandelbrot escape-time pixel block.
// Used by mandel_mul, mandel_div and mandelbrot_escape_time_pixel; depends on nothing.
`default_nettype none
package mandel_pkg;

  localparam int FRACTION_BITS = 28;
  localparam int MAX_DIMENSION = 4096;

  // Coordinate and iterate width: wide enough for a pixel mapped far outside the view.
  localparam int COORD_W = 48;
  localparam int CFG_W   = 32;
  localparam int PIX_W   = 12;
  localparam int DIM_W   = 13;
  localparam int CNT_W   = 16;
  localparam int COLOR_W = 24;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam int DIV_N_W   = 46;
  localparam int DIV_D_W   = 16;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_REAL_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 3'd6;

  localparam logic signed [COORD_W-1:0] TWO  = COORD_W'(64'sd2 <<< FRACTION_BITS);
  localparam logic signed [COORD_W-1:0] FOUR = COORD_W'(64'sd4 <<< FRACTION_BITS);
  localparam logic [MUL_W-1:0] COLOR_FULL = MUL_W'(24'hFFFFFF);

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAPX_MUL,
    ST_MAPX_START,
    ST_MAPX_WAIT,
    ST_MAPY_MUL,
    ST_MAPY_START,
    ST_MAPY_WAIT,
    ST_ITER_CHECK,
    ST_ITER_XX,
    ST_ITER_YY,
    ST_ITER_XY,
    ST_COLOR_MUL,
    ST_COLOR_START,
    ST_COLOR_WAIT,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

FILE: sv/mandel_mul.sv
// Shared signed multiplier with a registered product.
// Depends on mandel_pkg for operand widths and the request struct.
`default_nettype none
module mandel_mul import mandel_pkg::*; (
  input  wire logic                     clk,
  input  wire mul_req_t                 req,
  output logic signed [PROD_W-1:0]      prod
);

  logic signed [MUL_W-1:0] op_a;
  logic signed [MUL_W-1:0] op_b;

  assign op_a = $signed(req.a);
  assign op_b = $signed(req.b);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule
`default_nettype wire

FILE: sv/mandel_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mandel_pkg for widths and the request and response structs.
`default_nettype none
module mandel_div import mandel_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 running;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_N_W-1:0]   quo;
  logic [DIV_D_W-1:0]   dvsr;

  logic [DIV_D_W:0]     trial;
  logic                 fits;
  logic [DIV_D_W:0]     diff;
  logic [DIV_D_W-1:0]   rem_next;

  assign trial    = {rem, quo[DIV_N_W-1]};
  assign fits     = trial >= {1'b0, dvsr};
  assign diff     = trial - {1'b0, dvsr};
  assign rem_next = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
      end else if (running && cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
        running <= 1'b0;
        done_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo  <= req.dividend;
      dvsr <= req.divisor;
      rem  <= '0;
      cnt  <= '0;
    end else if (running) begin
      quo <= {quo[DIV_N_W-2:0], fits};
      rem <= rem_next;
      cnt <= cnt + 1'b1;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

FILE: sv/mandelbrot_escape_time_pixel.sv
// Mandelbrot escape-time pixel engine. Each pixel takes two divider passes to map its column
// and row and a third for the color unless the limit is zero (product, start, 46 quotient
// bits, done), and each iteration takes three products through the shared multiplier.
// One pixel is in work at a time; the next start is taken the cycle after done, and the
// receiver cannot stall the result.
// Synchronous reset returns to idle and loads the default view registers.
`default_nettype none
module mandelbrot_escape_time_pixel import mandel_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [PIX_W-1:0]     pixel_column,
  input  wire logic [PIX_W-1:0]     pixel_row,
  output logic                      done,
  output logic [PIX_W-1:0]          out_column,
  output logic [PIX_W-1:0]          out_row,
  output logic [CNT_W-1:0]          escape_count,
  output logic [COLOR_W-1:0]        pixel_color,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  state_t state, state_next;

  logic signed [CFG_W-1:0] real_min, real_max, imag_min, imag_max;
  logic [DIM_W-1:0]        image_columns, image_rows;
  logic [CNT_W-1:0]        iteration_limit;

  logic [PIX_W-1:0]          col_r, row_r;
  logic signed [COORD_W-1:0] x0, y0, x, y, xx, yy;
  logic [CNT_W-1:0]          count;
  logic [COLOR_W-1:0]        color;
  logic                      neg_r;

  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] prod;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  mandel_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  mandel_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Axis spans and clamped divisors.
  logic signed [MUL_W-1:0]   span_x, span_y;
  logic [DIV_D_W-1:0]        dvsr_x, dvsr_y;
  logic                      prod_neg;
  logic [PROD_W-1:0]         prod_mag;
  logic signed [COORD_W-1:0] quo_signed;
  logic signed [COORD_W-1:0] prod_fx;
  logic signed [COORD_W-1:0] x_new, y_new;
  logic                      out_of_range;
  logic                      escaped;

  assign span_x = MUL_W'(real_max) - MUL_W'(real_min);
  assign span_y = MUL_W'(imag_max) - MUL_W'(imag_min);

  always_comb begin
    if (image_columns == '0) begin
      dvsr_x = DIV_D_W'(1);
    end else if (image_columns > DIM_W'(MAX_DIMENSION)) begin
      dvsr_x = DIV_D_W'(MAX_DIMENSION);
    end else begin
      dvsr_x = DIV_D_W'(image_columns);
    end
    if (image_rows == '0) begin
      dvsr_y = DIV_D_W'(1);
    end else if (image_rows > DIM_W'(MAX_DIMENSION)) begin
      dvsr_y = DIV_D_W'(MAX_DIMENSION);
    end else begin
      dvsr_y = DIV_D_W'(image_rows);
    end
  end

  // The mapping quotient truncates toward zero, so divide the magnitude and restore the sign.
  assign prod_neg   = prod[PROD_W-1];
  assign prod_mag   = prod_neg ? (PROD_W'(0) - prod) : prod;
  assign quo_signed = neg_r ? (COORD_W'(0) - COORD_W'(div_rsp.quotient))
                            : COORD_W'(div_rsp.quotient);

  // Arithmetic shift gives the floor of the exact product.
  assign prod_fx = COORD_W'(prod >>> FRACTION_BITS);
  assign x_new   = xx - yy + x0;
  assign y_new   = prod_fx + y0;

  assign out_of_range = (x > TWO) || (x < -TWO) || (y > TWO) || (y < -TWO);
  assign escaped      = (xx + yy) > FOUR;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:        if (start) state_next = ST_MAPX_MUL;
      ST_MAPX_MUL:    state_next = ST_MAPX_START;
      ST_MAPX_START:  state_next = ST_MAPX_WAIT;
      ST_MAPX_WAIT:   if (div_rsp.done) state_next = ST_MAPY_MUL;
      ST_MAPY_MUL:    state_next = ST_MAPY_START;
      ST_MAPY_START:  state_next = ST_MAPY_WAIT;
      ST_MAPY_WAIT:   if (div_rsp.done) state_next = ST_ITER_CHECK;
      ST_ITER_CHECK: begin
        if (count >= iteration_limit || out_of_range) begin
          state_next = ST_COLOR_MUL;
        end else begin
          state_next = ST_ITER_XX;
        end
      end
      ST_ITER_XX:     state_next = ST_ITER_YY;
      ST_ITER_YY:     state_next = ST_ITER_XY;
      ST_ITER_XY:     state_next = escaped ? ST_COLOR_MUL : ST_ITER_CHECK;
      ST_COLOR_MUL:   state_next = (iteration_limit == '0) ? ST_FINISH : ST_COLOR_START;
      ST_COLOR_START: state_next = ST_COLOR_WAIT;
      ST_COLOR_WAIT:  if (div_rsp.done) state_next = ST_FINISH;
      ST_FINISH:      state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // Outputs: multiplier operands, divider requests and handshake.
  always_comb begin
    mul_req.a        = '0;
    mul_req.b        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_mag[DIV_N_W-1:0];
    div_req.divisor  = dvsr_x;
    busy             = (state != ST_IDLE);
    done             = (state == ST_FINISH);
    case (state)
      ST_MAPX_MUL: begin
        mul_req.a = span_x;
        mul_req.b = MUL_W'(col_r);
      end
      ST_MAPX_START: begin
        div_req.start = 1'b1;
      end
      ST_MAPY_MUL: begin
        mul_req.a = span_y;
        mul_req.b = MUL_W'(row_r);
      end
      ST_MAPY_START: begin
        div_req.start   = 1'b1;
        div_req.divisor = dvsr_y;
      end
      ST_ITER_CHECK: begin
        mul_req.a = x[MUL_W-1:0];
        mul_req.b = x[MUL_W-1:0];
      end
      ST_ITER_XX: begin
        mul_req.a = y[MUL_W-1:0];
        mul_req.b = y[MUL_W-1:0];
      end
      ST_ITER_YY: begin
        mul_req.a = {x[MUL_W-2:0], 1'b0};
        mul_req.b = y[MUL_W-1:0];
      end
      ST_COLOR_MUL: begin
        mul_req.a = MUL_W'(count);
        mul_req.b = COLOR_FULL;
      end
      ST_COLOR_START: begin
        div_req.start   = 1'b1;
        div_req.divisor = DIV_D_W'(iteration_limit);
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      real_min        <= -32'sd536870912;
      real_max        <= 32'sd536870912;
      imag_min        <= -32'sd536870912;
      imag_max        <= 32'sd536870912;
      image_columns   <= DIM_W'(1000);
      image_rows      <= DIM_W'(1000);
      iteration_limit <= CNT_W'(1000);
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_REAL_MIN:   real_min        <= cfg_data;
          CFG_REAL_MAX:   real_max        <= cfg_data;
          CFG_IMAG_MIN:   imag_min        <= cfg_data;
          CFG_IMAG_MAX:   imag_max        <= cfg_data;
          CFG_COLUMNS:    image_columns   <= cfg_data[DIM_W-1:0];
          CFG_ROWS:       image_rows      <= cfg_data[DIM_W-1:0];
          CFG_ITER_LIMIT: iteration_limit <= cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          col_r <= pixel_column;
          row_r <= pixel_row;
        end
      end
      ST_MAPX_START, ST_MAPY_START: neg_r <= prod_neg;
      ST_MAPX_WAIT: begin
        if (div_rsp.done) begin
          x0 <= COORD_W'(real_min) + quo_signed;
          x  <= COORD_W'(real_min) + quo_signed;
        end
      end
      ST_MAPY_WAIT: begin
        if (div_rsp.done) begin
          y0    <= COORD_W'(imag_min) + quo_signed;
          y     <= COORD_W'(imag_min) + quo_signed;
          count <= '0;
        end
      end
      ST_ITER_XX: xx <= prod_fx;
      ST_ITER_YY: yy <= prod_fx;
      ST_ITER_XY: begin
        if (!escaped) begin
          x     <= x_new;
          y     <= y_new;
          count <= count + 1'b1;
        end
      end
      ST_COLOR_MUL: begin
        if (iteration_limit == '0) begin
          color <= '0;
        end
      end
      ST_COLOR_WAIT: begin
        if (div_rsp.done) begin
          color <= div_rsp.quotient[COLOR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_column   = col_r;
  assign out_row      = row_r;
  assign escape_count = count;
  assign pixel_color  = color;

  // The iteration count never passes the limit it is checked against.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> escape_count <= iteration_limit)
    else $error("escape_count above iteration_limit");

  // An accepted pixel keeps the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after start transfer");

  // A result strobe lasts a single cycle and is followed by idle.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("done strobe longer than one cycle");

  // The divider is only waited on for the column mapping after it was started.
  a_div_started: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAPX_WAIT && $past(state) != ST_MAPX_WAIT) |-> $past(div_req.start))
    else $error("divider wait without a start");

endmodule
`default_nettype wire
